>>> rtl/sdlf_pkg.sv
// Shared constants and types for the star direction to local frame block.
package sdlf_pkg;

    // Default coordinate width (signed, two integer bits, the rest fraction)
    localparam int COORD_WIDTH_DEF = 16;

    // Width of the star kind tag
    localparam int KIND_W = 2;

    // Magnitudes are normalized so that the largest lies in [2^29, 2^30)
    localparam int NORM_W   = 30;
    localparam int NORM_TOP = NORM_W - 1;

    // Sum of three squares of normalized magnitudes and its integer root
    localparam int ROOT_W = NORM_W + 1;
    localparam int SQ_W   = 2 * ROOT_W;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AXIS_X   = 2'd0,
        REG_AXIS_Y   = 2'd1,
        REG_AXIS_Z   = 2'd2,
        REG_STARS_EN = 2'd3
    } cfg_idx_t;

endpackage

>>> rtl/sdlf_isqrt.sv
// Pipelined integer square root, one root bit resolved per stage.
module sdlf_isqrt #(
    parameter int ROOT_W = 31,
    parameter int TAG_W  = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2*ROOT_W-1:0]   radicand,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     root,
    output logic [TAG_W-1:0]      out_tag
);

    localparam int RW = 2 * ROOT_W + 2;

    logic [RW-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic [TAG_W-1:0]  tag_reg   [ROOT_W];
    logic              valid_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam int B = ROOT_W - 1 - i;

        logic [RW-1:0]     rem_src;
        logic [ROOT_W-1:0] root_src;
        logic [TAG_W-1:0]  tag_src;
        logic              valid_src;
        logic [RW-1:0]     trial;
        logic              take;

        if (i == 0)
        begin : g_first
            assign rem_src   = RW'(radicand);
            assign root_src  = '0;
            assign tag_src   = in_tag;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[i-1];
            assign root_src  = root_reg[i-1];
            assign tag_src   = tag_reg[i-1];
            assign valid_src = valid_reg[i-1];
        end

        // Growth of the square when this root bit is set
        assign trial = (RW'(root_src) << (B + 1)) | (RW'(1) << (2 * B));
        assign take  = (rem_src >= trial);

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_src;
            end
        end

        // Resolve one root bit
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= take ? (rem_src - trial) : rem_src;
                root_reg[i] <= take ? (root_src | (ROOT_W'(1) << B)) : root_src;
                tag_reg[i]  <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule

>>> rtl/sdlf_div3.sv
// Three-lane pipelined restoring divider, one quotient bit per stage.
module sdlf_div3 #(
    parameter int NW    = 48,
    parameter int DENW  = 31,
    parameter int QW    = 16,
    parameter int TAG_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [2:0][NW-1:0]    num,
    input  logic [DENW-1:0]       den,
    input  logic [TAG_W-1:0]      in_tag,
    output logic                  out_valid,
    output logic [2:0][QW-1:0]    quo,
    output logic [TAG_W-1:0]      out_tag
);

    logic [2:0][NW-1:0] rem_reg   [QW];
    logic [2:0][QW-1:0] quo_reg   [QW];
    logic [DENW-1:0]    den_reg   [QW];
    logic [TAG_W-1:0]   tag_reg   [QW];
    logic               valid_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        localparam int B = QW - 1 - i;

        logic [2:0][NW-1:0] rem_src;
        logic [2:0][QW-1:0] quo_src;
        logic [DENW-1:0]    den_src;
        logic [TAG_W-1:0]   tag_src;
        logic               valid_src;
        logic [NW-1:0]      dshift;

        if (i == 0)
        begin : g_first
            assign rem_src   = num;
            assign quo_src   = '0;
            assign den_src   = den;
            assign tag_src   = in_tag;
            assign valid_src = in_valid;
        end
        else
        begin : g_next
            assign rem_src   = rem_reg[i-1];
            assign quo_src   = quo_reg[i-1];
            assign den_src   = den_reg[i-1];
            assign tag_src   = tag_reg[i-1];
            assign valid_src = valid_reg[i-1];
        end

        assign dshift = NW'(den_src) << B;

        // Advance the valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= valid_src;
            end
        end

        // Resolve one quotient bit in each lane
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (rem_src[l] >= dshift)
                    begin
                        rem_reg[i][l] <= rem_src[l] - dshift;
                        quo_reg[i][l] <= quo_src[l] | (QW'(1) << B);
                    end
                    else
                    begin
                        rem_reg[i][l] <= rem_src[l];
                        quo_reg[i][l] <= quo_src[l];
                    end
                end
                den_reg[i] <= den_src;
                tag_reg[i] <= tag_src;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign quo       = quo_reg[QW-1];
    assign out_tag   = tag_reg[QW-1];

endmodule

>>> rtl/star_direction_to_local_frame.sv
// Top level: projects a star direction onto three basis vectors and renormalizes it.
//
// Takes one star per cycle while the output skid register is empty and returns
// its direction in the observer frame as unit-length signed Q1.14 (at the
// default width), with kind and end-of-frame passed along. From input
// transfer to the output register a star passes nine stages of dot product,
// magnitude normalization and sum of squares, 31 stages of square root (one
// root bit each), one numerator stage, COORD_WIDTH quotient stages and one
// sign/saturation stage. The pipeline holds as a whole only when the output
// skid register is full. With stars_enabled clear, items are taken and dropped.
// Write the basis registers only while no star is in flight.
module star_direction_to_local_frame #(
    parameter int COORD_WIDTH = sdlf_pkg::COORD_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // star stream in
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // tdata: star_x, star_y, star_z (low to high), zero padded to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]        s_axis_tdata,
    // tuser: star_kind
    input  logic [sdlf_pkg::KIND_W-1:0]               s_axis_tuser,
    input  logic                                      s_axis_tlast,
    // direction stream out
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // tdata: dir_x, dir_y, dir_z (low to high), zero padded to bytes
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]        m_axis_tdata,
    // tuser: kind_out
    output logic [sdlf_pkg::KIND_W-1:0]               m_axis_tuser,
    output logic                                      m_axis_tlast,
    // configuration write port
    input  logic                                      cfg_we,
    input  logic [sdlf_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [3*COORD_WIDTH-1:0]                  cfg_data
);

    import sdlf_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = CW - 2;
    localparam int PS    = (2 * CW > 61) ? (2 * CW - 61) : 0;
    localparam int PW    = 2 * CW - PS;
    localparam int DW    = PW + 2;
    localparam int AW    = 3 * CW;
    localparam int TDW   = ((AW + 7) / 8) * 8;
    localparam int G     = (DW + 7) / 8;
    localparam int GB    = G * 8;
    localparam int LPW   = $clog2(GB);
    localparam int SHW   = ((LPW > 5) ? LPW : 5) + 1;
    localparam int EW    = DW + NORM_W;
    localparam int QW    = F + 2;
    localparam int NW    = ROOT_W + QW;
    localparam int LIM   = 1 << F;
    localparam int TAG1  = 3 * NORM_W + 3 + 1 + KIND_W + 1;
    localparam int TAG2  = 3 + 1 + KIND_W + 1;
    localparam int OUT_W = AW + KIND_W + 1;

    // Bits of a packed register that lie beyond a 64-bit word read as zero
    function automatic logic [AW-1:0] low64_mask();
        logic [AW-1:0] m;
        for (int i = 0; i < AW; i++)
        begin
            m[i] = (i < 64);
        end
        return m;
    endfunction

    localparam logic [AW-1:0] RD_MASK = low64_mask();

    // Configuration registers
    logic [AW-1:0] axis_reg [3];
    logic          stars_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg[0]  <= '0;
            axis_reg[1]  <= '0;
            axis_reg[2]  <= '0;
            stars_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_AXIS_X:   axis_reg[0]  <= cfg_data & RD_MASK;
                REG_AXIS_Y:   axis_reg[1]  <= cfg_data & RD_MASK;
                REG_AXIS_Z:   axis_reg[2]  <= cfg_data & RD_MASK;
                REG_STARS_EN: stars_en_reg <= cfg_data[0];
                default:      stars_en_reg <= stars_en_reg;
            endcase
        end
    end

    // Global advance: hold every stage while the skid register is full
    logic adv;
    logic skid_valid_reg;

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    // Stage 1: nine products
    logic signed [CW-1:0]     star  [3];
    logic signed [CW-1:0]     aslc  [3][3];
    logic signed [2*CW-1:0]   full  [3][3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            star[k] = s_axis_tdata[k*CW +: CW];
        end
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                aslc[j][k] = axis_reg[j][k*CW +: CW];
                full[j][k] = star[k] * aslc[j][k];
            end
        end
    end

    logic [PW-1:0]     prod_reg [3][3];
    logic [KIND_W-1:0] s1_kind_reg;
    logic              s1_last_reg;
    logic              s1_valid_reg;

    // Stage 2: dot products
    logic [DW-1:0]     sum_reg [3];
    logic [KIND_W-1:0] s2_kind_reg;
    logic              s2_last_reg;
    logic              s2_valid_reg;

    // Stage 3: sign and magnitude
    logic [DW-1:0]     mag3_reg [3];
    logic [2:0]        neg3_reg;
    logic [KIND_W-1:0] s3_kind_reg;
    logic              s3_last_reg;
    logic              s3_valid_reg;

    // Stage 4: largest magnitude
    logic [DW-1:0]     mag4_reg [3];
    logic [DW-1:0]     mx_reg;
    logic [2:0]        neg4_reg;
    logic [KIND_W-1:0] s4_kind_reg;
    logic              s4_last_reg;
    logic              s4_valid_reg;

    // Stage 5: leading one within each byte group
    logic [DW-1:0]     mag5_reg [3];
    logic [G-1:0]      gnz_reg;
    logic [2:0]        gpos_reg [G];
    logic [2:0]        neg5_reg;
    logic [KIND_W-1:0] s5_kind_reg;
    logic              s5_last_reg;
    logic              s5_valid_reg;

    // Stage 6: leading one position
    logic [DW-1:0]     mag6_reg [3];
    logic [LPW-1:0]    lp_reg;
    logic              zero6_reg;
    logic [2:0]        neg6_reg;
    logic [KIND_W-1:0] s6_kind_reg;
    logic              s6_last_reg;
    logic              s6_valid_reg;

    // Stage 7: normalized magnitudes
    logic [NORM_W-1:0] nm7_reg [3];
    logic              zero7_reg;
    logic [2:0]        neg7_reg;
    logic [KIND_W-1:0] s7_kind_reg;
    logic              s7_last_reg;
    logic              s7_valid_reg;

    // Stage 8: squares
    logic [2*NORM_W-1:0] sq_reg [3];
    logic [NORM_W-1:0]   nm8_reg [3];
    logic                zero8_reg;
    logic [2:0]          neg8_reg;
    logic [KIND_W-1:0]   s8_kind_reg;
    logic                s8_last_reg;
    logic                s8_valid_reg;

    // Stage 9: sum of squares
    logic [SQ_W-1:0]   rad_reg;
    logic [TAG1-1:0]   tag9_reg;
    logic              s9_valid_reg;

    // Combinational helpers for stages 3 to 7
    logic [GB-1:0]     mxp;
    logic [G-1:0]      gnz;
    logic [2:0]        gpos [G];
    logic [LPW-1:0]    lp;
    logic [SHW-1:0]    lpx;
    logic [EW-1:0]     ext  [3];
    logic [DW-1:0]     mx;

    always_comb
    begin
        // largest of the three magnitudes
        mx = mag3_reg[0];
        if (mag3_reg[1] > mx)
        begin
            mx = mag3_reg[1];
        end
        if (mag3_reg[2] > mx)
        begin
            mx = mag3_reg[2];
        end

        // per-group leading one
        mxp = GB'(mx_reg);
        for (int g = 0; g < G; g++)
        begin
            gnz[g]  = |mxp[g*8 +: 8];
            gpos[g] = '0;
            for (int b = 0; b < 8; b++)
            begin
                if (mxp[g*8+b])
                begin
                    gpos[g] = 3'(b);
                end
            end
        end

        // highest non-empty group
        lp = '0;
        for (int g = 0; g < G; g++)
        begin
            if (gnz_reg[g])
            begin
                lp = LPW'(g * 8 + int'(gpos_reg[g]));
            end
        end

        // common shift that brings the largest into [2^29, 2^30)
        lpx = SHW'(lp_reg);
        for (int j = 0; j < 3; j++)
        begin
            if (lpx >= SHW'(NORM_TOP))
            begin
                ext[j] = EW'(mag6_reg[j]) >> (lpx - SHW'(NORM_TOP));
            end
            else
            begin
                ext[j] = EW'(mag6_reg[j]) << (SHW'(NORM_TOP) - lpx);
            end
        end
    end

    // Valid bits of stages 1 to 9
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
            s8_valid_reg <= 1'b0;
            s9_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            // drop stars at the door while disabled
            s1_valid_reg <= s_axis_tvalid & stars_en_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
            s8_valid_reg <= s7_valid_reg;
            s9_valid_reg <= s8_valid_reg;
        end
    end

    // Payload of stages 1 to 9
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[j][k] <= full[j][k][2*CW-1:PS];
                end
            end
            s1_kind_reg <= s_axis_tuser;
            s1_last_reg <= s_axis_tlast;

            for (int j = 0; j < 3; j++)
            begin
                sum_reg[j] <= {{2{prod_reg[j][0][PW-1]}}, prod_reg[j][0]}
                            + {{2{prod_reg[j][1][PW-1]}}, prod_reg[j][1]}
                            + {{2{prod_reg[j][2][PW-1]}}, prod_reg[j][2]};
            end
            s2_kind_reg <= s1_kind_reg;
            s2_last_reg <= s1_last_reg;

            for (int j = 0; j < 3; j++)
            begin
                neg3_reg[j] <= sum_reg[j][DW-1];
                mag3_reg[j] <= sum_reg[j][DW-1] ? (DW'(0) - sum_reg[j]) : sum_reg[j];
            end
            s3_kind_reg <= s2_kind_reg;
            s3_last_reg <= s2_last_reg;

            mag4_reg    <= mag3_reg;
            mx_reg      <= mx;
            neg4_reg    <= neg3_reg;
            s4_kind_reg <= s3_kind_reg;
            s4_last_reg <= s3_last_reg;

            mag5_reg    <= mag4_reg;
            gnz_reg     <= gnz;
            gpos_reg    <= gpos;
            neg5_reg    <= neg4_reg;
            s5_kind_reg <= s4_kind_reg;
            s5_last_reg <= s4_last_reg;

            mag6_reg    <= mag5_reg;
            lp_reg      <= lp;
            zero6_reg   <= ~|gnz_reg;
            neg6_reg    <= neg5_reg;
            s6_kind_reg <= s5_kind_reg;
            s6_last_reg <= s5_last_reg;

            for (int j = 0; j < 3; j++)
            begin
                nm7_reg[j] <= ext[j][NORM_W-1:0];
            end
            zero7_reg   <= zero6_reg;
            neg7_reg    <= neg6_reg;
            s7_kind_reg <= s6_kind_reg;
            s7_last_reg <= s6_last_reg;

            for (int j = 0; j < 3; j++)
            begin
                sq_reg[j] <= nm7_reg[j] * nm7_reg[j];
            end
            nm8_reg     <= nm7_reg;
            zero8_reg   <= zero7_reg;
            neg8_reg    <= neg7_reg;
            s8_kind_reg <= s7_kind_reg;
            s8_last_reg <= s7_last_reg;

            rad_reg  <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            tag9_reg <= {s8_last_reg, s8_kind_reg, zero8_reg, neg8_reg,
                         nm8_reg[2], nm8_reg[1], nm8_reg[0]};
        end
    end

    // Square root of the sum of squares
    logic              sq_valid;
    logic [ROOT_W-1:0] root;
    logic [TAG1-1:0]   tag_sq;

    sdlf_isqrt #(
        .ROOT_W (ROOT_W),
        .TAG_W  (TAG1)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s9_valid_reg),
        .radicand  (rad_reg),
        .in_tag    (tag9_reg),
        .out_valid (sq_valid),
        .root      (root),
        .out_tag   (tag_sq)
    );

    // Numerator stage: m * 2^F plus half the root, for rounding
    logic [2:0][NW-1:0] num_reg;
    logic [ROOT_W-1:0]  den_reg;
    logic [TAG2-1:0]    tag10_reg;
    logic               s10_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s10_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s10_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                num_reg[j] <= (NW'(tag_sq[j*NORM_W +: NORM_W]) << F) + NW'(root >> 1);
            end
            den_reg   <= root;
            tag10_reg <= tag_sq[TAG1-1:3*NORM_W];
        end
    end

    // Three rounded divisions
    logic               dv_valid;
    logic [2:0][QW-1:0] quo;
    logic [TAG2-1:0]    tag_dv;

    sdlf_div3 #(
        .NW    (NW),
        .DENW  (ROOT_W),
        .QW    (QW),
        .TAG_W (TAG2)
    ) u_div3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s10_valid_reg),
        .num       (num_reg),
        .den       (den_reg),
        .in_tag    (tag10_reg),
        .out_valid (dv_valid),
        .quo       (quo),
        .out_tag   (tag_dv)
    );

    // Final stage: saturate, restore sign, pack
    logic [2:0]        dv_neg;
    logic              dv_zero;
    logic [KIND_W-1:0] dv_kind;
    logic              dv_last;
    logic [QW-1:0]     qsat [3];
    logic [AW-1:0]     dir;

    assign dv_neg  = tag_dv[2:0];
    assign dv_zero = tag_dv[3];
    assign dv_kind = tag_dv[4 +: KIND_W];
    assign dv_last = tag_dv[4 + KIND_W];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            qsat[j] = (quo[j] > QW'(LIM)) ? QW'(LIM) : quo[j];
            if (dv_zero)
            begin
                dir[j*CW +: CW] = '0;
            end
            else if (dv_neg[j])
            begin
                dir[j*CW +: CW] = CW'(QW'(0) - qsat[j]);
            end
            else
            begin
                dir[j*CW +: CW] = CW'(qsat[j]);
            end
        end
    end

    logic [OUT_W-1:0] res_reg;
    logic             res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            res_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= {dv_last, dv_kind, dir};
        end
    end

    // Output register with skid: park a result when the sink stalls
    logic [OUT_W-1:0] out_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] skid_reg;
    logic             take_out;

    assign take_out = out_valid_reg & m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            priority if (adv && res_valid_reg)
            begin
                if (out_valid_reg && !m_axis_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (take_out)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else
            begin
                out_valid_reg <= out_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        priority if (adv && res_valid_reg)
        begin
            if (out_valid_reg && !m_axis_tready)
            begin
                skid_reg <= res_reg;
            end
            else
            begin
                out_reg <= res_reg;
            end
        end
        else if (take_out && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else
        begin
            out_reg <= out_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDW'(out_reg[AW-1:0]);
    assign m_axis_tuser  = out_reg[AW +: KIND_W];
    assign m_axis_tlast  = out_reg[AW + KIND_W];

endmodule

>>> bench/testbench.sv
// Testbench for the star direction to local frame block: directed table, random stars, self-checking.
`timescale 1ns / 100ps

module testbench;
    import sdlf_pkg::*;

    localparam int CW     = COORD_WIDTH_DEF;
    localparam int FB     = CW - 2;
    localparam int AW     = 3 * CW;
    localparam int DW     = ((3*CW+7)/8)*8;
    localparam int LAT    = 43 + CW;
    localparam int WD_MAX = 4000;
    localparam int N_RAND = 1400;

    typedef struct packed {
        logic [CW-1:0]     x;
        logic [CW-1:0]     y;
        logic [CW-1:0]     z;
        logic [KIND_W-1:0] kind;
        logic              last;
    } star_t;

    typedef struct packed {
        logic [CW-1:0]     dx;
        logic [CW-1:0]     dy;
        logic [CW-1:0]     dz;
        logic [KIND_W-1:0] kind;
        logic              fend;
    } dir_t;

    logic clk, rst_n;
    logic s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [DW-1:0] s_axis_tdata;
    logic [KIND_W-1:0] s_axis_tuser;
    logic m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [DW-1:0] m_axis_tdata;
    logic [KIND_W-1:0] m_axis_tuser;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [3*CW-1:0] cfg_data;

    // Shadow copy of the basis and enable registers
    logic [3*CW-1:0] basis [3];
    logic            emit_en;

    dir_t expected_dirs [$];
    int   err_count;
    int   idle_cycles;
    int   out_count;
    bit   no_idle;

    star_direction_to_local_frame #(.COORD_WIDTH(CW)) DUT (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n  -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Project onto the basis, then scale to unit length
    function automatic dir_t project_star(star_t st);
        longint          comp [3];
        longint          proj [3];
        longint unsigned mag [3];
        longint unsigned peak, sumsq, rt, q;
        bit              neg [3];
        logic [CW-1:0]   res [3];
        dir_t            d;
        comp[0] = longint'($signed(st.x));
        comp[1] = longint'($signed(st.y));
        comp[2] = longint'($signed(st.z));
        peak = 0;
        for (int j = 0; j < 3; j++)
        begin
            proj[j] = 0;
            for (int k = 0; k < 3; k++)
                proj[j] += comp[k] * longint'($signed(basis[j][k*CW +: CW]));
            neg[j] = proj[j] < 0;
            mag[j] = neg[j] ? -proj[j] : proj[j];
            if (mag[j] > peak) peak = mag[j];
        end
        if (peak == 0)
            foreach (res[j]) res[j] = '0;
        else
        begin
            while (peak >= (64'd1 << 30))
            begin
                foreach (mag[j]) mag[j] >>= 1;
                peak >>= 1;
            end
            while (peak < (64'd1 << 29))
            begin
                foreach (mag[j]) mag[j] <<= 1;
                peak <<= 1;
            end
            sumsq = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
            rt = root64(sumsq);
            for (int j = 0; j < 3; j++)
            begin
                q = ((mag[j] << FB) + (rt >> 1)) / rt;
                if (q > (64'd1 << FB)) q = 64'd1 << FB;
                res[j] = neg[j] ? CW'(-q) : CW'(q);
            end
        end
        d.dx = res[0];
        d.dy = res[1];
        d.dz = res[2];
        d.kind = st.kind;
        d.fend = st.last;
        return d;
    endfunction

    function automatic logic [3*CW-1:0] pack_vec(int vx, int vy, int vz);
        return {CW'(vz), CW'(vy), CW'(vx)};
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return CW'(-16384);
            1: return CW'(16384);
            2: return CW'($urandom);
            default: return CW'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    // Drop the star stream and write one register
    task automatic write_reg(cfg_idx_t idx, logic [3*CW-1:0] val);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STARS_EN)
            emit_en = val[0];
        else
            basis[idx] = val;
    endtask

    // Wait until every expected direction has arrived, then drain the pipe
    task automatic drain_pipe();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_dirs.size() != 0) @(negedge clk);
        repeat (LAT + 10) @(negedge clk);
    endtask

    // Present one star and hold it until the transfer; keep valid high so
    // that the next star can follow without a gap
    task automatic send_star(star_t st, bit chk, dir_t want);
        dir_t pred;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 19)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DW'({st.z, st.y, st.x});
        s_axis_tuser  <= st.kind;
        s_axis_tlast  <= st.last;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        if (emit_en)
        begin
            pred = project_star(st);
            if (chk && pred !== want)
            begin
                $error("table row disagrees with predictor: want %h pred %h", want, pred);
                err_count++;
            end
            expected_dirs.push_back(pred);
        end
    endtask

    task automatic random_basis();
        for (int j = 0; j < 3; j++)
        begin
            if ($urandom_range(0, 3) == 0)
                write_reg(cfg_idx_t'(j), AW'({$urandom, $urandom}));
            else
                write_reg(cfg_idx_t'(j), pack_vec(int'($signed(rand_coord())),
                                                  int'($signed(rand_coord())),
                                                  int'($signed(rand_coord()))));
        end
    endtask

    // Accept on the output side, compare against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            dir_t got, want;
            got.dx = m_axis_tdata[0 +: CW];
            got.dy = m_axis_tdata[CW +: CW];
            got.dz = m_axis_tdata[2*CW +: CW];
            got.kind = m_axis_tuser;
            got.fend = m_axis_tlast;
            out_count++;
            if (expected_dirs.size() == 0)
            begin
                $error("unexpected transfer on output: %h", got);
                err_count++;
            end
            else
            begin
                want = expected_dirs.pop_front();
                if (got.dx !== want.dx)
                begin
                    $error("dir_x expected %h actual %h", want.dx, got.dx);
                    err_count++;
                end
                if (got.dy !== want.dy)
                begin
                    $error("dir_y expected %h actual %h", want.dy, got.dy);
                    err_count++;
                end
                if (got.dz !== want.dz)
                begin
                    $error("dir_z expected %h actual %h", want.dz, got.dz);
                    err_count++;
                end
                if (got.kind !== want.kind)
                begin
                    $error("kind_out expected %h actual %h", want.kind, got.kind);
                    err_count++;
                end
                if (got.fend !== want.fend)
                begin
                    $error("frame_end expected %h actual %h", want.fend, got.fend);
                    err_count++;
                end
            end
        end
    end

    // Randomly stall the output side
    always @(negedge clk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 19);

    // Watchdog: count cycles without any transfer or register write
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_MAX)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    typedef struct {
        star_t st;
        bit    chk;
        dir_t  want;
    } row_t;

    row_t dir_table [$];

    function automatic star_t mk(int vx, int vy, int vz, int kd, int lst);
        star_t s;
        s.x = CW'(vx);
        s.y = CW'(vy);
        s.z = CW'(vz);
        s.kind = KIND_W'(kd);
        s.last = lst[0];
        return s;
    endfunction

    function automatic dir_t md(int vx, int vy, int vz, int kd, int lst);
        dir_t d;
        d.dx = CW'(vx);
        d.dy = CW'(vy);
        d.dz = CW'(vz);
        d.kind = KIND_W'(kd);
        d.fend = lst[0];
        return d;
    endfunction

    function automatic void add_row(star_t s, bit c, dir_t w);
        row_t r;
        r.st = s;
        r.chk = c;
        r.want = w;
        dir_table.push_back(r);
    endfunction

    initial
    begin
        star_t st;
        int    phase_len;
        err_count = 0;
        idle_cycles = 0;
        out_count = 0;
        no_idle = 0;
        emit_en = 0;
        foreach (basis[j]) basis[j] = '0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_AXIS_X;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Disabled after reset: stars are dropped
        send_star(mk(16384, 0, 0, 1, 1), 0, '0);

        // Identity basis, enable
        write_reg(REG_AXIS_X, pack_vec(16384, 0, 0));
        write_reg(REG_AXIS_Y, pack_vec(0, 16384, 0));
        write_reg(REG_AXIS_Z, pack_vec(0, 0, 16384));
        write_reg(REG_STARS_EN, AW'(1));

        add_row(mk(16384, 0, 0, 0, 0), 1, md(16384, 0, 0, 0, 0));
        add_row(mk(-16384, 0, 0, 1, 1), 1, md(-16384, 0, 0, 1, 1));
        add_row(mk(0, 16384, 0, 2, 0), 1, md(0, 16384, 0, 2, 0));
        add_row(mk(0, 0, -16384, 3, 1), 1, md(0, 0, -16384, 3, 1));
        add_row(mk(0, 0, 0, 2, 1), 1, md(0, 0, 0, 2, 1));
        add_row(mk(0, 0, 3, 0, 0), 1, md(0, 0, 16384, 0, 0));
        add_row(mk(-32768, 0, 0, 1, 0), 1, md(-16384, 0, 0, 1, 0));
        add_row(mk(32767, 32767, 32767, 3, 1), 0, '0);
        add_row(mk(-32768, -32768, -32768, 0, 0), 0, '0);
        add_row(mk(16384, 16384, 0, 1, 0), 0, '0);
        add_row(mk(1, -1, 1, 2, 1), 0, '0);
        add_row(mk(-16384, 16384, -16384, 0, 1), 0, '0);
        add_row(mk(12345, -6789, 321, 3, 0), 0, '0);
        foreach (dir_table[i])
            send_star(dir_table[i].st, dir_table[i].chk, dir_table[i].want);
        drain_pipe();

        // Extreme basis values
        write_reg(REG_AXIS_X, pack_vec(-32768, -32768, -32768));
        write_reg(REG_AXIS_Y, pack_vec(32767, 32767, 32767));
        write_reg(REG_AXIS_Z, '1);
        send_star(mk(-32768, -32768, -32768, 1, 0), 0, '0);
        send_star(mk(32767, -32768, 1, 2, 1), 0, '0);
        drain_pipe();
        write_reg(REG_AXIS_X, '0);
        write_reg(REG_AXIS_Y, '0);
        write_reg(REG_AXIS_Z, '0);
        send_star(mk(100, 200, 300, 1, 1), 1, md(0, 0, 0, 1, 1));
        drain_pipe();

        // Random phases, new basis each phase, enable mostly on
        for (int ph = 0; ph < 14; ph++)
        begin
            random_basis();
            write_reg(REG_STARS_EN, AW'((ph % 5 == 4) ? 0 : 1));
            no_idle = (ph == 6);
            phase_len = N_RAND / 14;
            for (int i = 0; i < phase_len; i++)
            begin
                st.x = rand_coord();
                st.y = rand_coord();
                st.z = rand_coord();
                st.kind = KIND_W'($urandom);
                st.last = ($urandom_range(0, 7) == 0);
                send_star(st, 0, '0);
            end
            drain_pipe();
        end
        no_idle = 0;

        $display("Covered %0d directions out: identity/extreme/zero bases, random bases,",
                 out_count);
        $display("enable on and off, random stalls on both sides.");
        if (err_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> sim.f
rtl/sdlf_pkg.sv
rtl/sdlf_isqrt.sv
rtl/sdlf_div3.sv
rtl/star_direction_to_local_frame.sv
bench/testbench.sv
